### rtl/mfmd_pkg.sv
// Shared types and constants for the multi-turn feedback decoder.
// Used by the controller, the datapath and the top level; no dependencies.

package mfmd_pkg;

   // Single-turn angle encoding
   localparam int unsigned ANGLE_BITS   = 13;
   localparam int unsigned ANGLE_CODES  = 1 << ANGLE_BITS;
   localparam int unsigned DEG_PER_TURN = 23592960;  // 360 deg in Q.16
   localparam int unsigned DEG_PER_CODE = DEG_PER_TURN / ANGLE_CODES;

   // Configuration register map
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam int unsigned CSR_DATA_BITS  = 25;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MOTOR_KIND         = 1'b0,
      REG_INVERSE_GEAR_RATIO = 1'b1
   } csr_index_type;

   // Datapath step issued by the controller each cycle
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_ROT,
      STEP_SPD,
      STEP_CUR,
      STEP_LO,
      STEP_HI,
      STEP_SUM,
      STEP_SAT
   } step_type;

   typedef struct packed {
      logic     accept;    // capture the input beat, update the turn count
      step_type step;      // operand select and result update
      logic     load_out;  // move finished results to the output register
   } cmd_type;

endpackage

### rtl/motor_feedback_multiturn_decoder_unit.sv
// Top level of the multi-turn feedback decoder.
// Depends on mfmd_pkg, mfmd_ctrl and mfmd_datapath.
//
//   channel | handshake                  | beat
//   req     | req_valid / req_ready      | angle, speed, current, temperature codes
//   rsp     | rsp_valid / rsp_ready      | angles, turn count, speed, current, temp
//   csr     | csr_write_enable           | csr_index, csr_write_data (no read-back)
//
// Between acceptance and rsp_valid a beat makes five passes through the single
// shared 34x31 multiplier plus the rounding and saturation steps.
// req_ready is high only while no beat is in work; a result waiting in the
// output register does not block the next request, but a new result holds
// in its last step until that register frees up. Synchronous reset clears
// the turn count, the last angle and the configuration (raw current, ratio 1).

module motor_feedback_multiturn_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mfmd_pkg::ANGLE_BITS-1:0]     req_angle_code,
   input  logic signed [15:0]                  req_speed_code,
   input  logic signed [15:0]                  req_current_code,
   input  logic [7:0]                          req_temperature_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [24:0]                         rsp_rotor_angle_deg,
   output logic signed [31:0]                  rsp_turn_count,
   output logic signed [56:0]                  rsp_rotor_total_deg,
   output logic signed [56:0]                  rsp_shaft_total_deg,
   output logic signed [31:0]                  rsp_shaft_speed,
   output logic signed [31:0]                  rsp_current_amps,
   output logic [7:0]                          rsp_temperature,
   input  logic                                csr_write_enable,
   input  logic [mfmd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mfmd_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   mfmd_pkg::cmd_type cmd;

   mfmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mfmd_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_angle_code       (req_angle_code),
      .req_speed_code       (req_speed_code),
      .req_current_code     (req_current_code),
      .req_temperature_code (req_temperature_code),
      .rsp_rotor_angle_deg  (rsp_rotor_angle_deg),
      .rsp_turn_count       (rsp_turn_count),
      .rsp_rotor_total_deg  (rsp_rotor_total_deg),
      .rsp_shaft_total_deg  (rsp_shaft_total_deg),
      .rsp_shaft_speed      (rsp_shaft_speed),
      .rsp_current_amps     (rsp_current_amps),
      .rsp_temperature      (rsp_temperature)
   );

endmodule

### rtl/mfmd_ctrl.sv
// Sequencer for the multi-turn feedback decoder.
// Depends on mfmd_pkg for the command struct and the step codes.

module mfmd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfmd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_SPD,
      ST_CUR,
      ST_LO,
      ST_HI,
      ST_SUM,
      ST_SAT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      load_out;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_ready & req_valid;
   // Hold in the last step until the output register is free
   assign load_out  = (state_ff == ST_SAT) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_ROT;
         ST_ROT:  state_in = ST_SPD;
         ST_SPD:  state_in = ST_CUR;
         ST_CUR:  state_in = ST_LO;
         ST_LO:   state_in = ST_HI;
         ST_HI:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_SAT;
         ST_SAT:  if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.accept   = accept;
      cmd.load_out = load_out;
      unique case (state_ff)
         ST_IDLE: cmd.step = mfmd_pkg::STEP_IDLE;
         ST_ROT:  cmd.step = mfmd_pkg::STEP_ROT;
         ST_SPD:  cmd.step = mfmd_pkg::STEP_SPD;
         ST_CUR:  cmd.step = mfmd_pkg::STEP_CUR;
         ST_LO:   cmd.step = mfmd_pkg::STEP_LO;
         ST_HI:   cmd.step = mfmd_pkg::STEP_HI;
         ST_SUM:  cmd.step = mfmd_pkg::STEP_SUM;
         ST_SAT:  cmd.step = mfmd_pkg::STEP_SAT;
         default: cmd.step = mfmd_pkg::STEP_IDLE;
      endcase
   end

endmodule

### rtl/mfmd_datapath.sv
// Datapath for the multi-turn feedback decoder: turn tracking, one shared
// signed multiplier, rounding, saturation and the output register.
// Depends on mfmd_pkg for constants and the command struct.

module mfmd_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mfmd_pkg::cmd_type                       cmd,
   input  logic                                    csr_write_enable,
   input  logic [mfmd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mfmd_pkg::CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic [mfmd_pkg::ANGLE_BITS-1:0]         req_angle_code,
   input  logic signed [15:0]                      req_speed_code,
   input  logic signed [15:0]                      req_current_code,
   input  logic [7:0]                              req_temperature_code,
   output logic [24:0]                             rsp_rotor_angle_deg,
   output logic signed [31:0]                      rsp_turn_count,
   output logic signed [56:0]                      rsp_rotor_total_deg,
   output logic signed [56:0]                      rsp_shaft_total_deg,
   output logic signed [31:0]                      rsp_shaft_speed,
   output logic signed [31:0]                      rsp_current_amps,
   output logic [7:0]                              rsp_temperature
);

   typedef enum logic [1:0] {
      KIND_20A = 2'd0,
      KIND_10A = 2'd1,
      KIND_3A  = 2'd2,
      KIND_RAW = 2'd3
   } motor_kind_type;

   localparam int unsigned AB = mfmd_pkg::ANGLE_BITS;
   localparam logic signed [AB:0] HALF_TURN = (AB+1)'(mfmd_pkg::ANGLE_CODES / 2);
   // ceil(2^36 / 125): exact floor division by 125 for dividends below 2^29
   localparam logic [29:0] RECIP_125 = 30'd549755814;
   localparam logic [57:0] SHAFT_LIM = 58'd1 << 56;
   localparam logic [33:0] SPEED_LIM = 34'd1 << 31;

   // Configuration
   motor_kind_type kind_ff;
   logic [24:0]    ratio_ff;

   // Turn tracking
   logic [AB-1:0]       prev_ff;
   logic signed [31:0]  revs_ff, revs_in;
   logic signed [AB:0]  angle_diff;

   // Captured beat
   logic [24:0] ang_ff;
   logic        spd_neg_ff, cur_neg_ff;
   logic [15:0] spd_mag_ff, cur_mag_ff;
   logic [7:0]  temp_ff;

   // Shared multiplier
   logic signed [33:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [64:0] prod_ff;
   logic [28:0]        cur_z;

   // Working registers
   logic [56:0] rtot_ff;
   logic [56:0] mag_ff;
   logic        neg_ff;
   logic [25:0] lor_ff;
   logic [57:0] q_ff;
   logic [31:0] spd_res_ff, cur_res_ff;

   // Step results
   logic [33:0] spd_round, spd_sat;
   logic [31:0] spd_res;
   logic [31:0] cur_q, cur_res;
   logic [25:0] lor;
   logic [57:0] shaft_lim, shaft_sat;
   logic [56:0] shaft_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_RAW;
         ratio_ff <= 25'd16777216;
      end else if (csr_write_enable) begin
         unique case (mfmd_pkg::csr_index_type'(csr_index))
            mfmd_pkg::REG_MOTOR_KIND:
               kind_ff <= motor_kind_type'(csr_write_data[1:0]);
            mfmd_pkg::REG_INVERSE_GEAR_RATIO:
               ratio_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A drop of more than half a turn is a forward wrap, a rise a backward one
   assign angle_diff = $signed({1'b0, req_angle_code}) - $signed({1'b0, prev_ff});

   always_comb begin
      if (angle_diff < -HALF_TURN) begin
         revs_in = revs_ff + 32'sd1;
      end else if (angle_diff > HALF_TURN) begin
         revs_in = revs_ff - 32'sd1;
      end else begin
         revs_in = revs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         revs_ff <= '0;
      end else if (cmd.accept) begin
         prev_ff <= req_angle_code;
         revs_ff <= revs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ang_ff     <= 25'(req_angle_code) * 25'(mfmd_pkg::DEG_PER_CODE);
         spd_neg_ff <= req_speed_code[15];
         spd_mag_ff <= req_speed_code[15] ? 16'(17'sd0 - 17'(req_speed_code))
                                          : 16'(req_speed_code);
         cur_neg_ff <= req_current_code[15];
         cur_mag_ff <= req_current_code[15] ? 16'(17'sd0 - 17'(req_current_code))
                                            : 16'(req_current_code);
         temp_ff    <= req_temperature_code;
      end
   end

   // code*10/10000 in Q.16 rounds as floor((code*8192 + 62) / 125)
   assign cur_z = {cur_mag_ff, 13'd0} + 29'd62;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.step)
         mfmd_pkg::STEP_ROT: begin
            mul_a = 34'(revs_ff);
            mul_b = 31'(mfmd_pkg::DEG_PER_TURN);
         end
         mfmd_pkg::STEP_SPD: begin
            mul_a = 34'(spd_mag_ff);
            mul_b = 31'(ratio_ff);
         end
         mfmd_pkg::STEP_CUR: begin
            mul_a = 34'(cur_z);
            mul_b = 31'(RECIP_125);
         end
         mfmd_pkg::STEP_LO: begin
            mul_a = 34'(mag_ff[23:0]);
            mul_b = 31'(ratio_ff);
         end
         mfmd_pkg::STEP_HI: begin
            mul_a = 34'(mag_ff[56:24]);
            mul_b = 31'(ratio_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 65'(mul_a) * 65'(mul_b);
   end

   // Speed: round off 8 bits, saturate, apply sign
   always_comb begin
      spd_round = 34'((42'(prod_ff[40:0]) + 42'd128) >> 8);
      spd_sat   = spd_neg_ff ? SPEED_LIM : SPEED_LIM - 34'd1;
      if (spd_round < spd_sat) spd_sat = spd_round;
      spd_res   = spd_neg_ff ? 32'(34'd0 - spd_sat) : 32'(spd_sat);
   end

   always_comb begin
      unique case (kind_ff)
         KIND_20A: cur_q = 32'({cur_mag_ff, 6'd0}) + 32'({cur_mag_ff, 4'd0});
         KIND_10A: cur_q = 32'(prod_ff[58:36]);
         KIND_3A:  cur_q = 32'({cur_mag_ff, 3'd0}) + 32'({cur_mag_ff, 2'd0});
         KIND_RAW: cur_q = {cur_mag_ff, 16'd0};
         default:  cur_q = '0;
      endcase
      cur_res = cur_neg_ff ? 32'd0 - cur_q : cur_q;
   end

   assign lor = 26'((50'(prod_ff[48:0]) + 50'(24'h800000)) >> 24);

   // Shaft angle: clamp the magnitude to the 57-bit signed range, apply sign
   always_comb begin
      shaft_lim = neg_ff ? SHAFT_LIM : SHAFT_LIM - 58'd1;
      shaft_sat = (q_ff > shaft_lim) ? shaft_lim : q_ff;
      shaft_res = neg_ff ? 57'(58'd0 - shaft_sat) : 57'(shaft_sat);
   end

   always_ff @(posedge clock) begin
      unique case (cmd.step)
         mfmd_pkg::STEP_SPD: begin
            rtot_ff <= prod_ff[56:0] + 57'(ang_ff);
         end
         mfmd_pkg::STEP_CUR: begin
            neg_ff     <= rtot_ff[56];
            mag_ff     <= rtot_ff[56] ? 57'd0 - rtot_ff : rtot_ff;
            spd_res_ff <= spd_res;
         end
         mfmd_pkg::STEP_LO: begin
            cur_res_ff <= cur_res;
         end
         mfmd_pkg::STEP_HI: begin
            lor_ff <= lor;
         end
         mfmd_pkg::STEP_SUM: begin
            q_ff <= prod_ff[57:0] + 58'(lor_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_rotor_angle_deg <= ang_ff;
         rsp_turn_count      <= revs_ff;
         rsp_rotor_total_deg <= rtot_ff;
         rsp_shaft_total_deg <= shaft_res;
         rsp_shaft_speed     <= spd_res_ff;
         rsp_current_amps    <= cur_res_ff;
         rsp_temperature     <= temp_ff;
      end
   end

endmodule

### rtl/mfmd_checker.sv
// Port-level checks for the multi-turn feedback decoder, bound to the top.
// Depends on mfmd_pkg for port widths.

module mfmd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [mfmd_pkg::ANGLE_BITS-1:0]     req_angle_code,
   input logic signed [15:0]                  req_speed_code,
   input logic signed [15:0]                  req_current_code,
   input logic [7:0]                          req_temperature_code,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [24:0]                         rsp_rotor_angle_deg,
   input logic signed [31:0]                  rsp_turn_count,
   input logic signed [56:0]                  rsp_rotor_total_deg,
   input logic signed [56:0]                  rsp_shaft_total_deg,
   input logic signed [31:0]                  rsp_shaft_speed,
   input logic signed [31:0]                  rsp_current_amps,
   input logic [7:0]                          rsp_temperature,
   input logic                                csr_write_enable,
   input logic [mfmd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [mfmd_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   // A stalled response beat stays valid and holds its turn count, shaft angle and current
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_turn_count)
         && $stable(rsp_shaft_total_deg) && $stable(rsp_current_amps))
      else $error("response payload changed while stalled");

   // One beat in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // With the output register free at acceptance, the beat never holds in its last step before rsp_valid rises
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |-> ##8 rsp_valid)
      else $error("result missing eight cycles after accept");

   // The single-turn part never flips the sign of the accumulated angle
   a_total_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rotor_total_deg[56] == rsp_turn_count[31])
      else $error("rotor total sign disagrees with turn count");

   // A non-negative rotor total gives a non-negative shaft angle
   a_shaft_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rotor_total_deg[56] |-> !rsp_shaft_total_deg[56])
      else $error("shaft angle negative for non-negative rotor total");

endmodule

bind motor_feedback_multiturn_decoder_unit mfmd_checker u_mfmd_checker (.*);

### verif/testbench.sv
// Self-checking testbench for motor_feedback_multiturn_decoder_unit.
// Drives feedback frames and register writes, predicts each result beat in Q.16 and
// compares it field by field; depends on mfmd_pkg and the decoder RTL.

module testbench;

   typedef struct packed {
      logic [24:0]        rotor_angle_deg;
      logic signed [31:0] turn_count;
      logic signed [56:0] rotor_total_deg;
      logic signed [56:0] shaft_total_deg;
      logic signed [31:0] shaft_speed;
      logic signed [31:0] current_amps;
      logic [7:0]         temperature;
   } feedback_type;

   typedef struct {
      logic [1:0]         kind;
      logic [24:0]        ratio;
      logic [12:0]        angle;
      logic signed [15:0] speed;
      logic signed [15:0] current;
      logic [7:0]         temp;
      bit                 typed;
      feedback_type       value;
   } frame_row_type;

   localparam logic [1:0]  KIND_20A = 2'd0;
   localparam logic [1:0]  KIND_10A = 2'd1;
   localparam logic [1:0]  KIND_3A  = 2'd2;
   localparam logic [1:0]  KIND_RAW = 2'd3;
   localparam logic [24:0] RATIO_ONE = 25'd16777216;
   localparam logic [24:0] RATIO_MAX = 25'h1FF_FFFF;

   localparam longint      HALF_TURN = 4096;
   localparam longint      TURN_Q16  = 23592960;
   localparam logic [63:0] MAX57     = 64'h00FF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MAX32     = 64'h7FFF_FFFF;

   localparam int RANDOM_PHASES    = 16;
   localparam int FRAMES_PER_PHASE = 119;
   localparam int WATCHDOG_CYCLES  = 2000;
   localparam int DRAIN_CYCLES     = 16;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [mfmd_pkg::ANGLE_BITS-1:0]     req_angle_code;
   logic signed [15:0]                  req_speed_code;
   logic signed [15:0]                  req_current_code;
   logic [7:0]                          req_temperature_code;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [24:0]                         rsp_rotor_angle_deg;
   logic signed [31:0]                  rsp_turn_count;
   logic signed [56:0]                  rsp_rotor_total_deg;
   logic signed [56:0]                  rsp_shaft_total_deg;
   logic signed [31:0]                  rsp_shaft_speed;
   logic signed [31:0]                  rsp_current_amps;
   logic [7:0]                          rsp_temperature;
   logic                                csr_write_enable;
   logic [mfmd_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [mfmd_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   // Decoder state as the predictor sees it
   logic [1:0]         kind_setting  = KIND_RAW;
   logic [24:0]        ratio_setting = RATIO_ONE;
   logic [12:0]        last_angle    = '0;
   logic signed [31:0] turns         = '0;

   feedback_type  pending_feedback[$];
   frame_row_type directed_rows[$];
   bit            row_typed = 1'b0;
   feedback_type  row_expect = '0;
   bit            steady = 1'b0;
   int            mismatches = 0;
   int            results_checked = 0;
   int            frames_sent = 0;
   int            settings_used = 0;
   int            idle_cycles = 0;
   int            turn_low = 0;
   int            turn_high = 0;

   motor_feedback_multiturn_decoder_unit dut (.*);

   always #10 clock = ~clock;

   function automatic logic [63:0] clamp_magnitude(input logic [63:0] q, input bit neg,
                                                   input logic [63:0] pos_max);
      logic [63:0] limit;
      limit = neg ? pos_max + 64'd1 : pos_max;
      return (q > limit) ? limit : q;
   endfunction

   // Advance the turn counter and work out one result beat
   function automatic feedback_type decode_frame(input logic [12:0] angle,
                                                 input logic signed [15:0] speed,
                                                 input logic signed [15:0] current,
                                                 input logic [7:0] temp);
      feedback_type       result;
      logic signed [63:0] delta;
      logic signed [63:0] rotor_total;
      logic [63:0]        mag;
      logic [63:0]        q;
      bit                 neg;
      delta = longint'(angle) - longint'(last_angle);
      if (delta < -HALF_TURN)
         turns = turns + 32'sd1;
      else if (delta > HALF_TURN)
         turns = turns - 32'sd1;
      last_angle = angle;

      result.rotor_angle_deg = 25'((longint'(angle) * TURN_Q16 + 4096) / 8192);
      result.turn_count = turns;
      rotor_total = turns * TURN_Q16 + longint'(result.rotor_angle_deg);
      result.rotor_total_deg = rotor_total[56:0];

      neg = rotor_total < 0;
      mag = neg ? -rotor_total : rotor_total;
      q = (mag >> 24) * ratio_setting
          + (((mag & 64'hFF_FFFF) * ratio_setting + 64'h80_0000) >> 24);
      q = clamp_magnitude(q, neg, MAX57);
      if (neg) q = -q;
      result.shaft_total_deg = q[56:0];

      neg = speed < 0;
      mag = longint'(speed);
      if (neg) mag = -mag;
      q = clamp_magnitude((mag * ratio_setting + 64'd128) >> 8, neg, MAX32);
      if (neg) q = -q;
      result.shaft_speed = q[31:0];

      neg = current < 0;
      mag = longint'(current);
      if (neg) mag = -mag;
      case (kind_setting)
         KIND_20A: q = mag * 80;
         KIND_10A: q = (mag * 65536 + 500) / 1000;
         KIND_3A:  q = mag * 12;
         default:  q = mag * 65536;
      endcase
      if (neg) q = -q;
      result.current_amps = q[31:0];
      result.temperature = temp;
      return result;
   endfunction

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 39))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] expected,
                              input logic signed [63:0] actual);
      if (expected !== actual) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, field, expected, actual);
      end
   endtask

   task automatic wait_drained();
      while (pending_feedback.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(input mfmd_pkg::csr_index_type idx,
                                 input logic [24:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(posedge clock);
      if (idx == mfmd_pkg::REG_MOTOR_KIND)
         kind_setting = value[1:0];
      else
         ratio_setting = value;
      @(negedge clock);
   endtask

   // Hold off until every result is back, then rewrite both registers
   task automatic apply_setting(input logic [1:0] kind, input logic [24:0] ratio);
      req_valid = 1'b0;
      wait_drained();
      write_register(mfmd_pkg::REG_MOTOR_KIND, {23'd0, kind});
      write_register(mfmd_pkg::REG_INVERSE_GEAR_RATIO, ratio);
      csr_write_enable = 1'b0;
      settings_used++;
   endtask

   task automatic send_frame(input logic [12:0] angle, input logic signed [15:0] speed,
                             input logic signed [15:0] current, input logic [7:0] temp,
                             input bit typed, input feedback_type value);
      if (!steady && $urandom_range(0, 99) < 22) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_angle_code = angle;
      req_speed_code = speed;
      req_current_code = current;
      req_temperature_code = temp;
      row_typed = typed;
      row_expect = value;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      frames_sent++;
   endtask

   always @(negedge clock) begin
      rsp_ready = steady || ($urandom_range(0, 99) >= 22);
   end

   always @(posedge clock) begin : track_beats
      feedback_type oldest;
      feedback_type predicted;
      bit           moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            if (pending_feedback.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with no frame outstanding", $time);
            end else begin
               oldest = pending_feedback.pop_front();
               check_field("rotor_angle_deg", oldest.rotor_angle_deg, rsp_rotor_angle_deg);
               check_field("turn_count", $signed(oldest.turn_count), rsp_turn_count);
               check_field("rotor_total_deg", $signed(oldest.rotor_total_deg),
                           rsp_rotor_total_deg);
               check_field("shaft_total_deg", $signed(oldest.shaft_total_deg),
                           rsp_shaft_total_deg);
               check_field("shaft_speed", $signed(oldest.shaft_speed), rsp_shaft_speed);
               check_field("current_amps", $signed(oldest.current_amps), rsp_current_amps);
               check_field("temperature", oldest.temperature, rsp_temperature);
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            predicted = decode_frame(req_angle_code, req_speed_code, req_current_code,
                                     req_temperature_code);
            pending_feedback.push_back(row_typed ? row_expect : predicted);
            if (turns < turn_low) turn_low = turns;
            if (turns > turn_high) turn_high = turns;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG_CYCLES) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int          phase;
      int          n;
      int          pick;
      int          step;
      logic [12:0] walk;
      logic [24:0] ratio;

      reset = 1'b1;
      req_valid = 1'b0;
      req_angle_code = '0;
      req_speed_code = '0;
      req_current_code = '0;
      req_temperature_code = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = mfmd_pkg::REG_MOTOR_KIND;
      csr_write_data = '0;

      // Reset state, full-scale swings and both turn directions
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd0, 16'sd0, 16'sd0,
                                              8'd0, 1'b1, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd8191, 16'sd32767,
                                              16'h8000, 8'd255, 1'b1,
                                              '{25'd23590080, -32'sd1, -57'sd2880,
                                                -57'sd2880, 32'sd2147418112,
                                                32'h8000_0000, 8'd255}});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd0, 16'h8000,
                                              16'sd32767, 8'd0, 1'b1,
                                              '{25'd0, 32'sd0, 57'sd0, 57'sd0,
                                                32'h8000_0000, 32'sd2147418112, 8'd0}});
      // Exactly half a turn either way holds the count; one code more moves it
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd4096, 16'h5555,
                                              16'hAAAA, 8'h5A, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd0, 16'hAAAA,
                                              16'h5555, 8'hA5, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd4097, 16'sd1,
                                              -16'sd1, 8'd1, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd0, -16'sd1,
                                              16'sd1, 8'd128, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd6000, 16'sd100,
                                              16'sd200, 8'd30, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd100, 16'sd100,
                                              16'sd200, 8'd31, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd4000, 16'sd100,
                                              16'sd200, 8'd32, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd8000, 16'sd100,
                                              16'sd200, 8'd33, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_ONE, 13'd50, 16'sd100,
                                              16'sd200, 8'd34, 1'b0, '0});
      // The 20A, 10A and 3A current scalings at both ends of the code range
      directed_rows.push_back(frame_row_type'{KIND_20A, RATIO_ONE, 13'd1000, -16'sd1,
                                              16'h8000, 8'd40, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_20A, RATIO_ONE, 13'd1000, 16'sd1,
                                              16'sd32767, 8'd41, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_10A, RATIO_ONE, 13'd1000, 16'sd5,
                                              16'h8000, 8'd42, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_10A, RATIO_ONE, 13'd1000, 16'sd5,
                                              16'sd32767, 8'd43, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_10A, RATIO_ONE, 13'd1000, 16'sd5,
                                              16'sd1, 8'd44, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_3A, RATIO_ONE, 13'd1000, 16'sd7,
                                              16'h8000, 8'd45, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_3A, RATIO_ONE, 13'd1000, 16'sd7,
                                              16'sd32767, 8'd46, 1'b0, '0});
      // Zero ratio, smallest ratio, and the widest ratio driving speed into saturation
      directed_rows.push_back(frame_row_type'{KIND_RAW, 25'd0, 13'd2000, 16'sd32767,
                                              16'sd9, 8'd50, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, 25'd1, 13'd3000, 16'h8000,
                                              16'sd9, 8'd51, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_MAX, 13'd7000, 16'sd32767,
                                              16'sd9, 8'd52, 1'b0, '0});
      directed_rows.push_back(frame_row_type'{KIND_RAW, RATIO_MAX, 13'd8191, 16'h8000,
                                              16'sd9, 8'd53, 1'b0, '0});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind != kind_setting || directed_rows[i].ratio != ratio_setting)
            apply_setting(directed_rows[i].kind, directed_rows[i].ratio);
         send_frame(directed_rows[i].angle, directed_rows[i].speed, directed_rows[i].current,
                    directed_rows[i].temp, directed_rows[i].typed, directed_rows[i].value);
      end

      walk = req_angle_code;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 5)
            0:       ratio = RATIO_ONE;
            1:       ratio = RATIO_MAX;
            2:       ratio = '0;
            3:       ratio = 25'd1;
            default: ratio = 25'($urandom_range(1, 16777216));
         endcase
         apply_setting(2'(phase % 4), ratio);
         steady = (phase == 5 || phase == 6);
         for (n = 0; n < FRAMES_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // Drift steadily one way so the turn count walks far from zero
               step = $urandom_range(0, 3000);
               if ((phase % 2 == 1) != ($urandom_range(0, 4) == 0)) step = -step;
               walk = walk + 13'(step);
            end else if (pick < 85) begin
               walk = walk + 13'(4095 + $urandom_range(0, 2));
            end else begin
               walk = 13'($urandom);
            end
            send_frame(walk, random_word(), random_word(), 8'($urandom), 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      steady = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d frames and %0d result beats under %0d register settings,",
               frames_sent, results_checked, settings_used);
      $display("all motor kinds, gear ratios 0 to full scale, turn count %0d to %0d",
               turn_low, turn_high);
      if (mismatches == 0 && pending_feedback.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_feedback.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
